// ===== rtl/software_timer_table_macros.svh =====
// Assertion macros for the software timer table checker.
// Included by the checker file only.
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define STT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// Shared types and constants for the software timer table.
// Used by the slot cell, the top level and the checker.
package stt_pkg;

  localparam int OP_W   = 3;
  localparam int SRC_W  = 8;
  localparam int DUR_W  = 32;
  localparam int SLOT_W = 3;
  localparam int ST_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 3'd0,
    OP_RESTART  = 3'd1,
    OP_DELETE   = 3'd2,
    OP_TICK     = 3'd3,
    OP_CHECK    = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE         = 3'd0,
    ST_FULL         = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_EXPIRED      = 3'd3,
    ST_NONE_EXPIRED = 3'd4
  } status_t;

  // Command token that travels down the row of slot cells.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SRC_W-1:0]  source;
    logic [DUR_W-1:0]  duration;
    logic [DUR_W-1:0]  tick;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              pend;
    logic [SRC_W-1:0]  pend_src;
    logic [SLOT_W-1:0] pend_idx;
  } token_t;

  // Expired result pushed out by a cell during a check.
  typedef struct packed {
    logic              req;
    logic [SRC_W-1:0]  src;
    logic [SLOT_W-1:0] idx;
  } emit_t;

endpackage

// ===== rtl/stt_cell.sv =====
// One timer slot cell: holds the slot state and forwards the command token.
// Depends on stt_pkg for the token and emit types.
module stt_cell
  import stt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   go,
  input  token_t tok_i,
  output token_t tok_o,
  output emit_t  emit_o
);

  localparam logic [SLOT_W-1:0] IDX_L = SLOT_W'(IDX);

  logic             used_r,  used_nxt;
  logic [SRC_W-1:0] src_r,   src_nxt;
  logic [DUR_W-1:0] start_r, start_nxt;
  logic [DUR_W-1:0] dur_r,   dur_nxt;
  token_t           tok_r,   tok_nxt;
  logic             match;
  logic             expired;
  logic [DUR_W-1:0] elapsed;

  assign match   = (src_r == tok_i.source);
  assign elapsed = tok_i.tick - start_r;
  assign expired = used_r && (elapsed >= dur_r);

  always_comb begin
    used_nxt  = used_r;
    src_nxt   = src_r;
    start_nxt = start_r;
    dur_nxt   = dur_r;
    tok_nxt   = tok_i;
    emit_o    = '0;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_REGISTER: begin
          if (!tok_i.hit && !used_r) begin
            used_nxt        = 1'b1;
            src_nxt         = tok_i.source;
            start_nxt       = tok_i.tick;
            dur_nxt         = tok_i.duration;
            tok_nxt.hit     = 1'b1;
            tok_nxt.hit_idx = IDX_L;
          end
        end
        OP_RESTART: begin
          if (match) begin
            start_nxt = tok_i.tick;
            if (!tok_i.hit) begin
              tok_nxt.hit     = 1'b1;
              tok_nxt.hit_idx = IDX_L;
            end
          end
        end
        OP_DELETE: begin
          if (!tok_i.hit && match) begin
            used_nxt        = 1'b0;
            src_nxt         = '0;
            tok_nxt.hit     = 1'b1;
            tok_nxt.hit_idx = IDX_L;
          end
        end
        OP_CHECK: begin
          if (expired) begin
            emit_o.req       = tok_i.pend;
            emit_o.src       = tok_i.pend_src;
            emit_o.idx       = tok_i.pend_idx;
            tok_nxt.pend     = 1'b1;
            tok_nxt.pend_src = src_r;
            tok_nxt.pend_idx = IDX_L;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      src_r   <= '0;
      start_r <= '0;
      dur_r   <= '0;
      tok_r   <= '0;
    end else if (go) begin
      used_r  <= used_nxt;
      src_r   <= src_nxt;
      start_r <= start_nxt;
      dur_r   <= dur_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== rtl/software_timer_table.sv =====
// An item is accepted into the entry register, walks one slot cell per cycle
// while the output is not stalled, and its final result is registered in the
// output register; expired results of a check appear as the command passes
// further expired slots. A new item is not accepted until the final result of
// the last one has been registered. Reset (synchronous, active low) clears the
// tick counter and every slot to zero.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [SRC_W-1:0]  in_src,
  input  logic [DUR_W-1:0]  in_duration,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [SRC_W-1:0]  out_source_out,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_last
);

  token_t              tok [SLOTS+1];
  emit_t               emit [SLOTS];
  emit_t               emit_any;
  token_t              fin;
  token_t              tok0_r, tok0_nxt;
  logic                busy_r, busy_nxt;
  logic [DUR_W-1:0]    now_r, now_nxt;
  logic                out_valid_r;
  logic [ST_W-1:0]     out_status_r;
  logic [SRC_W-1:0]    out_src_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_last_r;
  logic                accept;
  logic                op_ok;
  logic                can_load;
  logic                go;
  status_t             fin_status;
  logic [SRC_W-1:0]    fin_src;
  logic [SLOT_W-1:0]   fin_idx;

  assign op_ok    = (in_op <= OP_W'(OP_CHECK));
  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign can_load = !out_valid_r || !out_stall;
  assign fin      = tok[SLOTS];
  assign go       = can_load || !(emit_any.req || fin.valid);
  assign tok[0]   = tok0_r;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    stt_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .go     (go),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .emit_o (emit[i])
    );
  end

  always_comb begin
    emit_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      emit_any = emit_any | emit[i];
    end
  end

  always_comb begin
    fin_status = ST_DONE;
    fin_src    = fin.source;
    fin_idx    = fin.hit_idx;
    case (fin.op)
      OP_REGISTER: begin
        if (!fin.hit) begin
          fin_status = ST_FULL;
          fin_idx    = '0;
        end
      end
      OP_RESTART, OP_DELETE: begin
        if (!fin.hit) begin
          fin_status = ST_NOT_FOUND;
          fin_idx    = '0;
        end
      end
      OP_TICK: begin
        fin_src = '0;
        fin_idx = '0;
      end
      OP_CHECK: begin
        if (fin.pend) begin
          fin_status = ST_EXPIRED;
          fin_src    = fin.pend_src;
          fin_idx    = fin.pend_idx;
        end else begin
          fin_status = ST_NONE_EXPIRED;
          fin_src    = '0;
          fin_idx    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tok0_nxt = tok0_r;
    busy_nxt = busy_r;
    now_nxt  = now_r;
    if (go) begin
      tok0_nxt.valid = 1'b0;
    end
    if (accept && op_ok) begin
      tok0_nxt          = '0;
      tok0_nxt.valid    = 1'b1;
      tok0_nxt.op       = op_t'(in_op);
      tok0_nxt.source   = in_src;
      tok0_nxt.duration = in_duration;
      tok0_nxt.tick     = now_r;
      busy_nxt          = 1'b1;
    end
    if (fin.valid && can_load) begin
      busy_nxt = 1'b0;
      if (fin.op == OP_TICK) begin
        now_nxt = now_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r      <= '0;
      busy_r      <= 1'b0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tok0_r <= tok0_nxt;
      busy_r <= busy_nxt;
      now_r  <= now_nxt;
      if (can_load) begin
        out_valid_r <= emit_any.req || fin.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (emit_any.req) begin
        out_status_r <= ST_EXPIRED;
        out_src_r    <= emit_any.src;
        out_slot_r   <= emit_any.idx;
        out_last_r   <= 1'b0;
      end else if (fin.valid) begin
        out_status_r <= fin_status;
        out_src_r    <= fin_src;
        out_slot_r   <= fin_idx;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_source_out = out_src_r;
  assign out_slot       = out_slot_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/stt_chk.sv =====
// Port-level checker for the software timer table, bound to the top level.
// Depends on stt_pkg and the assertion macros header.
`include "software_timer_table_macros.svh"

module stt_chk
  import stt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [OP_W-1:0]   in_op,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ST_W-1:0]   out_status,
  input logic [SRC_W-1:0]  out_source_out,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_last
);

  `STT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall && in_op <= OP_W'(OP_CHECK), in_stall, "block not busy after accepting an item")
  `STT_ASSERT_NOW(a_single_last, clk, rst_n, out_valid && out_status != ST_EXPIRED, out_last, "single-result status without last")
  `STT_ASSERT_NOW(a_none_expired_zero, clk, rst_n, out_valid && out_status == ST_NONE_EXPIRED, out_source_out == '0 && out_slot == '0, "nothing-expired result with nonzero fields")
  `STT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_slot) && $stable(out_last), "stalled result changed")

endmodule

bind software_timer_table stt_chk u_stt_chk (.*);
